// ===== sv/mp2_pkg.sv =====
package mp2_pkg;

   localparam int MaxOrbitalsDefault = 64;
   localparam int FracBitsDefault    = 24;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_TERM  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] MODE_RESTRICTED = 2'd0;
   localparam logic [1:0] MODE_SAME_SPIN  = 2'd1;
   localparam logic [1:0] MODE_OPPOSITE   = 2'd2;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_ZERO  = 2'd1;
   localparam logic [1:0] FAULT_RANGE = 2'd2;
   localparam logic [1:0] FAULT_SAT   = 2'd3;

   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_OCC_FIRST = 3'd1;
   localparam logic [2:0] CSR_OCC_SECOND = 3'd2;
   localparam logic [2:0] CSR_VIR_FIRST = 3'd3;
   localparam logic [2:0] CSR_VIR_SECOND = 3'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic               spin_sel;
      logic [5:0]         orb_index;
      logic signed [31:0] orb_energy;
      logic [5:0]         occ_i;
      logic [5:0]         occ_j;
      logic [5:0]         vir_a;
      logic [5:0]         vir_b;
      logic signed [31:0] eri_direct;
      logic signed [31:0] eri_exchange;
   } req_type_type;

   typedef struct packed {
      logic signed [31:0] amplitude;
      logic signed [47:0] energy_sum;
      logic               skipped;
      logic [1:0]         fault_code;
   } rsp_type_type;

   // Divider control: start pulse with operands, done with quotient.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [33:0] divisor;
   } div_cmd_type;

endpackage

// ===== sv/mp2_pair_energy_accumulator.sv =====
// Pair-energy accumulator for second-order perturbation theory. Orbital
// energies are first loaded into two spin stores (request type 0); integral
// requests (type 1) then read four energies, form the denominator
// eps_i + eps_j - eps_a - eps_b, divide the integral numerator by it and add
// amplitude times factor into a saturating Q16.32 accumulator; type 2 clears
// the accumulator. A load, a clear or a spare request type goes from ST_READ0
// back to idle and gives no response. An integral request that faults on its
// indices or on the spare mode, or is skipped, goes from ST_READ0 to ST_OUT,
// which answers once the output register is free, and then returns to idle.
// A zero denominator is found in ST_READ4, once the four store reads are done,
// and answers through ST_OUT. A full term passes through the read states
// ST_READ0 to ST_READ4 of the single-port energy stores, ST_DIV for the
// bit-serial divider (one quotient bit per cycle over a 64-bit dividend) and
// ST_MUL, ST_SCALE and ST_ACC for the multiply, the scaling and the
// accumulate. One request is in work at a time; a finished response waits in
// the output register while the next request is taken, and a stalled
// response holds the following one in its last stage. Energy store entries
// must be loaded before use.
module mp2_pair_energy_accumulator
   import mp2_pkg::*;
#(
   parameter int MAX_ORBITALS = MaxOrbitalsDefault,
   parameter int FRAC_BITS    = FracBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type_type rsp_data,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [6:0]   csr_data
);

   localparam int AddrBits  = $clog2(MAX_ORBITALS);
   localparam int MaxVal    = MAX_ORBITALS;
   localparam int ShiftDown = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
   localparam int ShiftUp   = (2 * FRAC_BITS >= 32) ? 0 : 32 - 2 * FRAC_BITS;
   localparam logic [64:0] CapAt = 65'd1 << 48;
   localparam logic signed [47:0] AccMax = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] AccMin = {1'b1, {47{1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ0, ST_READ1, ST_READ2, ST_READ3, ST_READ4,
      ST_DIV, ST_SCALE, ST_MUL, ST_ACC, ST_OUT
   } state_type;

   // Configuration registers.
   logic [1:0] mode_ff;
   logic [6:0] occ_first_ff, occ_second_ff, vir_first_ff, vir_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESTRICTED;
         occ_first_ff  <= '0;
         occ_second_ff <= '0;
         vir_first_ff  <= '0;
         vir_second_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:       mode_ff       <= csr_data[1:0];
            CSR_OCC_FIRST:  occ_first_ff  <= csr_data;
            CSR_OCC_SECOND: occ_second_ff <= csr_data;
            CSR_VIR_FIRST:  vir_first_ff  <= csr_data;
            CSR_VIR_SECOND: vir_second_ff <= csr_data;
            default: ;
         endcase
      end
   end

   state_type    state_ff;
   req_type_type req_data_ff;
   logic         rsp_valid_ff;
   rsp_type_type rsp_data_ff;
   logic signed [47:0] acc_ff;
   logic signed [33:0] den_ff;
   logic signed [33:0] num_ff, fac_ff;
   logic         neg_ff, sat_ff;
   logic [31:0]  qmag_ff;
   logic [32:0]  fmag_ff;
   logic [64:0]  prod_ff;
   logic [48:0]  cm_ff;
   logic         csign_ff;
   div_cmd_type  div_cmd;
   logic         div_done;
   logic [63:0]  div_q;

   // The two spin stores, each one synchronous single-port memory. Both see
   // the same address; spin selection gates the writes and picks the read data.
   logic [31:0] store_first  [MAX_ORBITALS];
   logic [31:0] store_second [MAX_ORBITALS];
   logic [31:0] rd_first_ff, rd_second_ff;
   logic [AddrBits-1:0] mem_addr;
   logic we_first, we_second;

   always_ff @(posedge clock) begin
      if (we_first) store_first[mem_addr] <= req_data_ff.orb_energy;
      if (we_second) store_second[mem_addr] <= req_data_ff.orb_energy;
      rd_first_ff  <= store_first[mem_addr];
      rd_second_ff <= store_second[mem_addr];
   end

   mp2_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_q)
   );

   // Per-term decode from the held request.
   logic [1:0] m;
   logic       sel;
   logic       si, sj;
   logic [6:0] oi, oj, vi, vj;
   logic       bad, skip;
   logic signed [33:0] d34, x34, num_c, fac_c;

   always_comb begin
      m   = mode_ff;
      sel = req_data_ff.spin_sel;
      si  = (m == MODE_SAME_SPIN) && sel;
      sj  = si || (m == MODE_OPPOSITE);
      oi = occ_first_ff; oj = occ_first_ff;
      vi = vir_first_ff; vj = vir_first_ff;
      d34 = 34'(req_data_ff.eri_direct);
      x34 = 34'(req_data_ff.eri_exchange);
      num_c = d34;
      fac_c = (d34 <<< 1) - x34;
      if (m == MODE_SAME_SPIN) begin
         if (sel) begin
            oi = occ_second_ff; oj = occ_second_ff;
            vi = vir_second_ff; vj = vir_second_ff;
         end
         num_c = d34 - x34;
         fac_c = num_c;
      end else if (m == MODE_OPPOSITE) begin
         oj = occ_second_ff; vj = vir_second_ff;
         fac_c = d34;
      end
      bad = (m == 2'd3)
         || ({1'b0, req_data_ff.occ_i} >= oi) || ({1'b0, req_data_ff.occ_j} >= oj)
         || ({1'b0, req_data_ff.vir_a} >= vi) || ({1'b0, req_data_ff.vir_b} >= vj)
         || (32'(req_data_ff.occ_i) >= MaxVal) || (32'(req_data_ff.occ_j) >= MaxVal)
         || (32'(req_data_ff.vir_a) + 32'(oi) >= MaxVal)
         || (32'(req_data_ff.vir_b) + 32'(oj) >= MaxVal);
      skip = (m == MODE_SAME_SPIN) && ((req_data_ff.occ_j <= req_data_ff.occ_i)
         || (req_data_ff.vir_b <= req_data_ff.vir_a));
   end

   // Read address sequencing: i, j, a+oi, b+oj, one per cycle; the data of
   // each read is in the read register one state later.
   logic [7:0] raddr;
   always_comb begin
      unique case (state_ff)
         ST_READ1: raddr = 8'(req_data_ff.occ_j);
         ST_READ2: raddr = 8'(req_data_ff.vir_a) + 8'(oi);
         ST_READ3: raddr = 8'(req_data_ff.vir_b) + 8'(oj);
         default:  raddr = 8'(req_data_ff.occ_i);
      endcase
      we_first  = (state_ff == ST_READ0) && (req_data_ff.req_type == REQ_LOAD)
                  && !req_data_ff.spin_sel && (32'(req_data_ff.orb_index) < MaxVal);
      we_second = (state_ff == ST_READ0) && (req_data_ff.req_type == REQ_LOAD)
                  && req_data_ff.spin_sel && (32'(req_data_ff.orb_index) < MaxVal);
      if (req_data_ff.req_type == REQ_LOAD) begin
         mem_addr = AddrBits'(req_data_ff.orb_index);
      end else begin
         mem_addr = AddrBits'(raddr);
      end
   end

   logic [31:0] rd_i, rd_j;
   assign rd_i = si ? rd_second_ff : rd_first_ff;
   assign rd_j = sj ? rd_second_ff : rd_first_ff;

   logic        out_free;
   logic        rsp_load;
   logic signed [33:0] den_c;
   logic [33:0] num_mag, den_mag;
   logic [31:0] qsat;
   logic        qover;
   logic [64:0] cm_wide;
   logic [48:0] cm_c;
   logic signed [49:0] sum_c;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = out_free && ((state_ff == ST_ACC) || (state_ff == ST_OUT));
   // The last subtrahend arrives in ST_READ4 and completes the denominator.
   assign den_c    = den_ff - 34'(signed'(rd_j));
   assign num_mag  = num_ff[33] ? 34'(-num_ff) : 34'(num_ff);
   assign den_mag  = den_c[33] ? 34'(-den_c) : 34'(den_c);
   always_comb begin
      qover = 1'b0;
      qsat  = div_q[31:0];
      if (!neg_ff && div_q > 64'h7FFF_FFFF) begin qsat = 32'h7FFF_FFFF; qover = 1'b1; end
      if (neg_ff && div_q > 64'h8000_0000) begin qsat = 32'h8000_0000; qover = 1'b1; end
      // Bring the product to 32 fraction bits; its magnitude is capped at 2^48.
      if (2 * FRAC_BITS >= 32) begin
         cm_wide = prod_ff >> ShiftDown;
      end else if (prod_ff > (CapAt >> ShiftUp)) begin
         cm_wide = CapAt;
      end else begin
         cm_wide = prod_ff << ShiftUp;
      end
      cm_c = (cm_wide > CapAt) ? CapAt[48:0] : cm_wide[48:0];
      sum_c = csign_ff ? 50'(acc_ff) - 50'(cm_ff) : 50'(acc_ff) + 50'(cm_ff);
   end

   assign div_cmd.start    = (state_ff == ST_READ4) && (den_c != 0);
   assign div_cmd.dividend = 64'(num_mag) << FRAC_BITS;
   assign div_cmd.divisor  = den_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_data_ff <= req_data;
                  state_ff    <= ST_READ0;
               end
            end
            ST_READ0: begin
               // Loads are written here; faulted and skipped terms go straight to ST_OUT.
               num_ff <= num_c; fac_ff <= fac_c;
               if (req_data_ff.req_type == REQ_CLEAR) acc_ff <= '0;
               if (req_data_ff.req_type != REQ_TERM) begin
                  state_ff <= ST_IDLE;
               end else if (bad || skip) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_READ1;
               end
            end
            ST_READ1: begin
               den_ff <= 34'(signed'(rd_i)); state_ff <= ST_READ2;
            end
            ST_READ2: begin
               den_ff <= den_ff + 34'(signed'(rd_j)); state_ff <= ST_READ3;
            end
            ST_READ3: begin
               den_ff <= den_ff - 34'(signed'(rd_i)); state_ff <= ST_READ4;
            end
            ST_READ4: begin
               neg_ff   <= num_ff[33] != den_c[33];
               state_ff <= (den_c != 0) ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
               if (div_done) begin
                  qmag_ff  <= qsat;
                  sat_ff   <= qover;
                  fmag_ff  <= fac_ff[33] ? 33'(-fac_ff) : 33'(fac_ff);
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= 65'(qmag_ff) * 65'(fmag_ff);
               csign_ff <= neg_ff ^ fac_ff[33];
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               cm_ff    <= cm_c;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (out_free) begin
                  rsp_data_ff.amplitude <= neg_ff ? 32'(-qmag_ff) : qmag_ff;
                  rsp_data_ff.skipped   <= 1'b0;
                  if (sum_c > 50'(AccMax)) begin
                     acc_ff <= AccMax; rsp_data_ff.energy_sum <= AccMax;
                     rsp_data_ff.fault_code <= FAULT_SAT;
                  end else if (sum_c < 50'(AccMin)) begin
                     acc_ff <= AccMin; rsp_data_ff.energy_sum <= AccMin;
                     rsp_data_ff.fault_code <= FAULT_SAT;
                  end else begin
                     acc_ff <= sum_c[47:0]; rsp_data_ff.energy_sum <= sum_c[47:0];
                     rsp_data_ff.fault_code <= sat_ff ? FAULT_SAT : FAULT_NONE;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_data_ff.amplitude  <= '0;
                  rsp_data_ff.energy_sum <= acc_ff;
                  rsp_data_ff.skipped    <= !bad && skip;
                  rsp_data_ff.fault_code <= bad ? FAULT_RANGE
                                                : (skip ? FAULT_NONE : FAULT_ZERO);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/mp2_divider.sv =====
module mp2_divider
   import mp2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output logic        done,
   output logic [63:0] quotient
);

   // Restoring radix-2 division, one quotient bit per cycle.
   logic [63:0] quo_ff, quo_in;
   logic [34:0] rem_ff, rem_in;
   logic [33:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[33:0], quo_ff[63]} - {1'b0, dvs_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[34]) begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[33:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
